// ----- sv/hhm_pkg.sv -----
`default_nettype none

package hhm_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int PATTERN_WORDS     = 4;
  localparam int PATTERN_BYTES     = 8 * PATTERN_WORDS;
  localparam int PLEN_W            = 6;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(MAX_PATTERN_BYTES);

  localparam logic [2:0] VERDICT_MATCH    = 3'd0;
  localparam logic [2:0] VERDICT_NOT_IP   = 3'd1;
  localparam logic [2:0] VERDICT_NOT_TCP  = 3'd2;
  localparam logic [2:0] VERDICT_NO_HOST  = 3'd3;
  localparam logic [2:0] VERDICT_MISMATCH = 3'd4;
  localparam logic [2:0] VERDICT_TRUNC    = 3'd5;

  localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [2:0] CFG_PATTERN_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_PATTERN_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_PATTERN_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_PATTERN_WORD_3 = 3'd4;

  localparam logic [2:0] KEYWORD_LEN = 3'd6;
  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP    = 8'h06;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  typedef struct packed {
    logic [PLEN_W-1:0]                 length;
    logic [PATTERN_BYTES-1:0][7:0]     pattern;
  } hhm_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } hhm_word_t;

  // "Host: " one character per position
  function automatic logic [7:0] keyword_byte(input logic [2:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        3'd0:    c = 8'h48;
        3'd1:    c = 8'h6f;
        3'd2:    c = 8'h73;
        3'd3:    c = 8'h74;
        3'd4:    c = 8'h3a;
        3'd5:    c = 8'h20;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/hhm_parse.sv -----
`default_nettype none

module hhm_parse
  import hhm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hhm_word_t  word,
  input  wire logic       advance,
  input  wire hhm_cfg_t   cfg,
  output logic [2:0]      result
);

  logic [15:0]       pos;
  logic [3:0]        ihl;
  logic [3:0]        tcp;
  logic [15:0]       tot;
  logic [2:0]        kp;
  logic [PLEN_W-1:0] pp;
  logic [2:0]        status;
  logic              final_flag;

  logic [15:0]       pos_next;
  logic [3:0]        ihl_next;
  logic [3:0]        tcp_next;
  logic [15:0]       tot_next;
  logic [2:0]        kp_next;
  logic [PLEN_W-1:0] pp_next;
  logic [2:0]        status_next;
  logic              final_next;

  logic [7:0]        b;
  logic [6:0]        tcp_pos;
  logic [7:0]        hdrs_new;
  logic [7:0]        start;
  logic [16:0]       end17;
  logic [16:0]       p17;
  logic [PLEN_W-1:0] plen;
  logic [PLEN_W-1:0] pp_inc;

  always_comb begin
    b        = word.data;
    plen     = (cfg.length > PLEN_MAX) ? PLEN_MAX : cfg.length;
    tcp_pos  = 7'd26 + {1'b0, ihl, 2'b00};
    hdrs_new = {2'b00, ihl, 2'b00} + {2'b00, b[7:4], 2'b00};
    start    = 8'd14 + {2'b00, ihl, 2'b00} + {2'b00, tcp, 2'b00};
    end17    = {1'b0, tot} + 17'd14;
    p17      = {1'b0, pos};
    pp_inc   = pp + PLEN_W'(1);

    pos_next    = pos;
    ihl_next    = ihl;
    tcp_next    = tcp;
    tot_next    = tot;
    kp_next     = kp;
    pp_next     = pp;
    status_next = status;
    final_next  = final_flag;

    if (pos != 16'hffff) begin
      pos_next = pos + 16'd1;
      if (!final_flag) begin
        if (pos == 16'd12) begin
          if (b != ETHERTYPE_HI) begin
            status_next = VERDICT_NOT_IP;
            final_next  = 1'b1;
          end
        end else if (pos == 16'd13) begin
          if (b != ETHERTYPE_LO) begin
            status_next = VERDICT_NOT_IP;
            final_next  = 1'b1;
          end
        end else if (pos == 16'd14) begin
          ihl_next = b[3:0];
        end else if (pos == 16'd16) begin
          tot_next = {b, 8'h00};
        end else if (pos == 16'd17) begin
          tot_next = {tot[15:8], b};
        end else if (pos == 16'd23) begin
          if (b != PROTO_TCP) begin
            status_next = VERDICT_NOT_TCP;
            final_next  = 1'b1;
          end else if (ihl < MIN_HDR_WORDS) begin
            status_next = VERDICT_NOT_IP;
            final_next  = 1'b1;
          end
        end else if (pos >= 16'd26 && tcp == 4'd0) begin
          if (pos == {9'd0, tcp_pos}) begin
            if (b[7:4] < MIN_HDR_WORDS) begin
              status_next = VERDICT_NOT_TCP;
              final_next  = 1'b1;
            end else begin
              tcp_next = b[7:4];
              if (tot <= {8'd0, hdrs_new}) begin
                status_next = VERDICT_NO_HOST;
                final_next  = 1'b1;
              end
            end
          end
        end else if (tcp != 4'd0) begin
          if (p17 >= {9'd0, start} && p17 < end17) begin
            if (kp < KEYWORD_LEN) begin
              if (b == keyword_byte(kp)) begin
                kp_next = kp + 3'd1;
              end else begin
                kp_next = (b == keyword_byte(3'd0)) ? 3'd1 : 3'd0;
              end
              if (kp_next == KEYWORD_LEN) begin
                if (plen == '0) begin
                  status_next = VERDICT_MATCH;
                  final_next  = 1'b1;
                end else if (p17 + {11'd0, plen} >= end17) begin
                  status_next = VERDICT_MISMATCH;
                  final_next  = 1'b1;
                end else begin
                  pp_next = '0;
                end
              end
            end else begin
              if (b != cfg.pattern[pp[4:0]]) begin
                status_next = VERDICT_MISMATCH;
                final_next  = 1'b1;
              end else begin
                pp_next = pp_inc;
                if (pp_inc >= plen) begin
                  status_next = VERDICT_MATCH;
                  final_next  = 1'b1;
                end
              end
            end
            // payload ran out with nothing decided
            if (!final_next && p17 + 17'd1 == end17) begin
              status_next = VERDICT_NO_HOST;
              final_next  = 1'b1;
            end
          end
        end
      end
    end

    result = final_next ? status_next : VERDICT_TRUNC;

    if (word.last) begin
      pos_next    = '0;
      ihl_next    = '0;
      tcp_next    = '0;
      tot_next    = '0;
      kp_next     = '0;
      pp_next     = '0;
      status_next = VERDICT_TRUNC;
      final_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ihl        <= '0;
      tcp        <= '0;
      tot        <= '0;
      kp         <= '0;
      pp         <= '0;
      status     <= VERDICT_TRUNC;
      final_flag <= 1'b0;
    end else if (advance) begin
      pos        <= pos_next;
      ihl        <= ihl_next;
      tcp        <= tcp_next;
      tot        <= tot_next;
      kp         <= kp_next;
      pp         <= pp_next;
      status     <= status_next;
      final_flag <= final_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/http_host_header_match.sv -----
// HTTP Host header filter for Ethernet/IPv4/TCP frames.
// Input channel: one frame byte per word (frame_byte, frame_last), moved by
// in_valid / in_stall, starting at the destination MAC.
// Output channel: one word per frame (verdict, host_matched), moved by
// out_valid / out_stall, issued for the word that carries frame_last.
// Configuration: cfg_write with cfg_index 0 sets pattern_length, indexes
// 1 to 4 set pattern_word_0..3 (64 bits, byte k in bits 8k upward). Write
// only while no frame is in flight.
// Throughput: one byte per cycle while in_stall is low. Each byte is held in the input
// register and is parsed by combinational logic into the frame state.
// Verdict path: the last byte is registered in the input register, and the verdict
// is registered in the output register when that byte leaves the input register.
// Stall: a pending verdict holds in the output register while out_stall is
// high; bytes keep flowing until the next last byte reaches the input
// register, which then waits and raises in_stall.
// Reset: clears the pattern registers, the frame state and both valids.
module http_host_header_match
  import hhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       verdict,
  output logic             host_matched,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  hhm_cfg_t   cfg;
  hhm_word_t  s1;
  logic       s1_valid_next;
  logic       hold;
  logic       advance;
  logic       out_load;
  logic       out_valid_next;
  logic [2:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: cfg.length <= cfg_data[PLEN_W-1:0];
        CFG_PATTERN_WORD_0: cfg.pattern[7:0]   <= cfg_data;
        CFG_PATTERN_WORD_1: cfg.pattern[15:8]  <= cfg_data;
        CFG_PATTERN_WORD_2: cfg.pattern[23:16] <= cfg_data;
        CFG_PATTERN_WORD_3: cfg.pattern[31:24] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the last byte while the previous verdict is still waiting
  assign hold          = s1.valid && s1.last && out_valid && out_stall;
  assign in_stall      = hold;
  assign advance       = s1.valid && !hold;
  assign s1_valid_next = (in_valid && !in_stall) || hold;
  assign out_load      = advance && s1.last;
  assign out_valid_next = out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_valid_next;
      if (in_valid && !in_stall) begin
        s1.data <= frame_byte;
        s1.last <= frame_last;
      end
    end
  end

  hhm_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .word    (s1),
    .advance (advance),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict      <= result;
      host_matched <= (result == VERDICT_MATCH);
    end
  end

  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (host_matched == (verdict == VERDICT_MATCH)))
    else $error("host_matched disagrees with verdict");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (s1.valid && s1.last && out_valid && out_stall))
    else $error("input stalled without a blocked verdict");

  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.last && !in_stall) |=> out_valid)
    else $error("last byte did not produce a verdict");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(s1.valid && s1.last)) |=> !out_valid)
    else $error("verdict repeated after being taken");

endmodule

`default_nettype wire
